>>> sv/rpp_pkg.sv
// Package for the rotate-about-pivot pipeline: fixed-point formats, angle constants,
// the CORDIC arctangent table and the stage payload type.
// No dependencies; every other file of the block refers to it by scoped names.
package rpp_pkg;

  // Datapath widths. Offsets carry 16 guard bits below the Q16.16 point.
  localparam int XW          = 52;
  localparam int ZW          = 26;
  localparam int GUARD_BITS  = 16;
  localparam int TABLE_LEN   = 32;
  localparam int ATAN_W      = 23;

  // Defaults for the top-level parameters.
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 16;

  // Reciprocal of the CORDIC gain for many stages, Q0.30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // Angles in Q16.16 degrees.
  localparam logic signed [ZW-1:0] FULL_TURN    = 26'sd23592960;
  localparam logic signed [ZW-1:0] HALF_TURN    = 26'sd11796480;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd5898240;

  // The angle is biased by 2^31 to make it unsigned; this is that bias modulo a full turn.
  localparam logic signed [ZW-1:0] ANGLE_BIAS = ZW'((64'd1 << 31) % 64'(FULL_TURN));

  // Quotient bits of the restoring angle reduction, and the stages in front of the CORDIC.
  localparam int ANGLE_QBITS = 8;
  localparam int PREP_DEPTH  = ANGLE_QBITS + 2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
  } stage_t;

  // atan(2^-i) in Q16.16 degrees, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_deg(input int idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      0:       v = 23'd2949120;
      1:       v = 23'd1740967;
      2:       v = 23'd919879;
      3:       v = 23'd466945;
      4:       v = 23'd234379;
      5:       v = 23'd117304;
      6:       v = 23'd58666;
      7:       v = 23'd29335;
      8:       v = 23'd14668;
      9:       v = 23'd7334;
      10:      v = 23'd3667;
      11:      v = 23'd1833;
      12:      v = 23'd917;
      13:      v = 23'd458;
      14:      v = 23'd229;
      15:      v = 23'd115;
      16:      v = 23'd57;
      17:      v = 23'd29;
      18:      v = 23'd14;
      19:      v = 23'd7;
      20:      v = 23'd4;
      21:      v = 23'd2;
      22:      v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/rpp_prep.sv
// Front stages: offset from the pivot, gain pre-scaling, angle reduction modulo 360
// degrees and the quarter-turn fold. Depends on rpp_pkg.
module rpp_prep (
  input  logic                                clk,
  input  logic [rpp_pkg::PREP_DEPTH-1:0]      en,
  input  logic signed [31:0]                  pivot_x,
  input  logic signed [31:0]                  pivot_y,
  input  logic signed [31:0]                  point_x,
  input  logic signed [31:0]                  point_y,
  input  logic signed [31:0]                  angle_deg,
  output rpp_pkg::stage_t                     q
);

  localparam int QB = rpp_pkg::ANGLE_QBITS;
  localparam int XW = rpp_pkg::XW;
  localparam int ZW = rpp_pkg::ZW;

  logic [31:0]        u_q  [0:QB];
  logic signed [31:0] px_q [0:QB];
  logic signed [31:0] py_q [0:QB];
  logic signed [XW-1:0] gx_q [2:QB];
  logic signed [XW-1:0] gy_q [2:QB];

  logic signed [32:0] dx_q, dy_q;
  logic               nx_q, ny_q;
  logic [45:0]        phx_q, plx_q, phy_q, ply_q;

  logic [31:0] magx, magy;
  logic [61:0] sumx, sumy;
  logic [47:0] qx, qy;

  // Stage 0: capture, take offsets and bias the angle to an unsigned value.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_q[0] <= pivot_x;
      py_q[0] <= pivot_y;
      dx_q    <= {point_x[31], point_x} - {pivot_x[31], pivot_x};
      dy_q    <= {point_y[31], point_y} - {pivot_y[31], pivot_y};
      u_q[0]  <= {~angle_deg[31], angle_deg[30:0]};
    end
  end

  // Stage 1: magnitudes times the gain, as two 16 x 30 partial products each.
  always_comb begin
    magx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
    magy = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      nx_q  <= dx_q[32];
      ny_q  <= dy_q[32];
      phx_q <= magx[31:16] * rpp_pkg::GAIN_Q30;
      plx_q <= magx[15:0]  * rpp_pkg::GAIN_Q30;
      phy_q <= magy[31:16] * rpp_pkg::GAIN_Q30;
      ply_q <= magy[15:0]  * rpp_pkg::GAIN_Q30;
    end
  end

  // Stage 2: sum the partials, round half away from zero to 16 guard bits, restore sign.
  always_comb begin
    sumx = {phx_q, 16'd0} + {16'd0, plx_q} + 62'd8192;
    sumy = {phy_q, 16'd0} + {16'd0, ply_q} + 62'd8192;
    qx   = sumx[61:14];
    qy   = sumy[61:14];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      gx_q[2] <= nx_q ? -$signed({4'd0, qx}) : $signed({4'd0, qx});
      gy_q[2] <= ny_q ? -$signed({4'd0, qy}) : $signed({4'd0, qy});
    end
  end

  // Stages 1 to QB: restoring reduction of the biased angle, one quotient bit a stage.
  for (genvar s = 1; s <= QB; s++) begin : g_mod
    localparam logic [31:0] DIV_K = 32'(rpp_pkg::FULL_TURN) << (QB - s);
    always_ff @(posedge clk) begin
      if (en[s]) begin
        u_q[s]  <= (u_q[s-1] >= DIV_K) ? u_q[s-1] - DIV_K : u_q[s-1];
        px_q[s] <= px_q[s-1];
        py_q[s] <= py_q[s-1];
      end
    end
  end

  for (genvar s = 3; s <= QB; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[s]) begin
        gx_q[s] <= gx_q[s-1];
        gy_q[s] <= gy_q[s-1];
      end
    end
  end

  // Last stage: remove the bias, map to [-180, 180) and fold into [-90, 90].
  logic signed [ZW-1:0] z0, z1, z2, zf;
  logic signed [XW-1:0] xf, yf;

  always_comb begin
    z0 = $signed({1'b0, u_q[QB][ZW-2:0]}) - rpp_pkg::ANGLE_BIAS;
    z1 = (z0 < 0) ? z0 + rpp_pkg::FULL_TURN : z0;
    z2 = (z1 >= rpp_pkg::HALF_TURN) ? z1 - rpp_pkg::FULL_TURN : z1;
    xf = gx_q[QB];
    yf = gy_q[QB];
    zf = z2;
    if (z2 > rpp_pkg::QUARTER_TURN) begin
      xf = -gy_q[QB];
      yf = gx_q[QB];
      zf = z2 - rpp_pkg::QUARTER_TURN;
    end else if (z2 < -rpp_pkg::QUARTER_TURN) begin
      xf = gy_q[QB];
      yf = -gx_q[QB];
      zf = z2 + rpp_pkg::QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      q.x  <= xf;
      q.y  <= yf;
      q.z  <= zf;
      q.px <= px_q[QB];
      q.py <= py_q[QB];
    end
  end

endmodule

>>> sv/rpp_cordic_stage.sv
// One registered CORDIC rotation-mode iteration with a fixed shift.
// Depends on rpp_pkg for the payload type and the arctangent table.
module rpp_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  rpp_pkg::stage_t d,
  output rpp_pkg::stage_t q
);

  localparam int ZW = rpp_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN =
    $signed({{(ZW - rpp_pkg::ATAN_W){1'b0}}, rpp_pkg::atan_deg(IDX)});

  logic signed [rpp_pkg::XW-1:0] xs, ys;

  always_comb begin
    xs = d.x >>> IDX;
    ys = d.y >>> IDX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d.z >= 0) begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - ATAN;
      end else begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + ATAN;
      end
      q.px <= d.px;
      q.py <= d.py;
    end
  end

endmodule

>>> sv/rpp_finish.sv
// Output stage: drop the guard bits, add the pivot back and saturate.
// Depends on rpp_pkg; its registers are the block's result registers.
module rpp_finish #(
  parameter int COORD_WIDTH = rpp_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  rpp_pkg::stage_t    d,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic               overflow
);

  localparam int XW       = rpp_pkg::XW;
  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [37:0] SAT_HI = (38'sd1 <<< (SAT_BITS - 1)) - 38'sd1;
  localparam logic signed [37:0] SAT_LO = -SAT_HI - 38'sd1;

  logic signed [XW-1:0] xr, yr;
  logic signed [37:0]   sx, sy;
  logic                 ox, oy;
  logic signed [37:0]   cx, cy;

  always_comb begin
    xr = d.x + XW'(64'd1 << (rpp_pkg::GUARD_BITS - 1));
    yr = d.y + XW'(64'd1 << (rpp_pkg::GUARD_BITS - 1));
    sx = {{2{xr[XW-1]}}, xr[XW-1:rpp_pkg::GUARD_BITS]} + {{6{d.px[31]}}, d.px};
    sy = {{2{yr[XW-1]}}, yr[XW-1:rpp_pkg::GUARD_BITS]} + {{6{d.py[31]}}, d.py};
    ox = (sx > SAT_HI) || (sx < SAT_LO);
    oy = (sy > SAT_HI) || (sy < SAT_LO);
    cx = (sx > SAT_HI) ? SAT_HI : ((sx < SAT_LO) ? SAT_LO : sx);
    cy = (sy > SAT_HI) ? SAT_HI : ((sy < SAT_LO) ? SAT_LO : sy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rotated_x <= cx[31:0];
      rotated_y <= cy[31:0];
      overflow  <= ox || oy;
    end
  end

endmodule

>>> sv/rotate_point_about_pivot_unit.sv
// Top level of the rotate-about-pivot unit: handshake, valid pipeline and stage wiring.
// Depends on rpp_pkg, rpp_prep, rpp_cordic_stage and rpp_finish.
//
// This unit rotates a point counter-clockwise about a pivot by an angle in degrees, all
// signed Q16.16, and keeps no state between transactions. It accepts one transaction
// per clock unless point_stall is high and returns one result transaction for each, in
// order. A transaction passes 10 + CORDIC_STAGES + 1 register stages (CORDIC_STAGES is
// capped at 32), and the first of them loads at the accepting edge. Ten front stages take
// the offset from the pivot, scale it by the CORDIC gain in two 16 x 30 partial-product
// steps, and reduce the angle modulo 360 degrees with one quotient bit per stage; then
// each CORDIC iteration is a register stage of its own; the last stage rounds, adds the
// pivot back and saturates to min(COORD_WIDTH, 32) bits, raising overflow when either
// coordinate was clipped. Every stage holds a valid bit and advances when it is empty or
// the stage after it advances, so empty slots close up under result_stall and point_stall
// rises only when all stages hold live transactions and the result is stalled.
// result_valid comes straight from a register.
module rotate_point_about_pivot_unit #(
  parameter int COORD_WIDTH   = rpp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = rpp_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] angle_deg,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] rotated_x,
  output logic signed [31:0] rotated_y,
  output logic               overflow
);

  localparam int PD    = rpp_pkg::PREP_DEPTH;
  localparam int NS    = (CORDIC_STAGES > rpp_pkg::TABLE_LEN) ? rpp_pkg::TABLE_LEN
                                                              : CORDIC_STAGES;
  localparam int DEPTH = PD + NS + 1;

  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] en;

  rpp_pkg::stage_t chain [0:NS];

  // A stage may load when it is empty or its contents move on in the same cycle.
  assign en[DEPTH-1] = !vld[DEPTH-1] || !result_stall;
  for (genvar k = 0; k < DEPTH - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= point_valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign point_stall  = !en[0];
  assign result_valid = vld[DEPTH-1];

  rpp_prep u_prep (
    .clk       (clk),
    .en        (en[PD-1:0]),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .point_x   (point_x),
    .point_y   (point_y),
    .angle_deg (angle_deg),
    .q         (chain[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    rpp_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk (clk),
      .en  (en[PD+i]),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  rpp_finish #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_finish (
    .clk       (clk),
    .en        (en[DEPTH-1]),
    .d         (chain[NS]),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .overflow  (overflow)
  );

  // Saturation bounds of the result coordinates.
  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [31:0] SAT_HI = (32'sd1 <<< (SAT_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

`ifndef ASSERT_OFF
  // With no result waiting, nothing can hold the input back.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !point_stall)
    else $error("input stalled while the result register is empty");

  // The input may only stall when every stage holds a live transaction.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> ((&vld) && result_stall))
    else $error("input stalled with an empty slot in the pipeline");

  // A raised overflow flag means a coordinate sits at a saturation bound.
  a_overflow_at_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && overflow) |->
      (rotated_x == SAT_HI || rotated_x == SAT_LO ||
       rotated_y == SAT_HI || rotated_y == SAT_LO))
    else $error("overflow flagged without a saturated coordinate");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for rotate_point_about_pivot_unit: drives rotation transactions,
// predicts each result in fixed point and compares it with what the unit returns.
// Depends on rpp_pkg for the gain and angle constants and on the unit itself.
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_W  = rpp_pkg::COORD_WIDTH_DEF;
  localparam int STAGES   = rpp_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY  = 10 + ((STAGES > 32) ? 32 : STAGES) + 1;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS  = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DEG = 65536;

  typedef struct packed {
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] angle_deg;
  } point_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
  } rotated_t;

  // Holds the rotations still owed by the unit and works out each one as its input
  // transaction is accepted.
  class rotation_scoreboard;
    localparam longint FULL_T    = rpp_pkg::FULL_TURN;
    localparam longint HALF_T    = rpp_pkg::HALF_TURN;
    localparam longint QUARTER_T = rpp_pkg::QUARTER_TURN;
    localparam int     GB        = rpp_pkg::GUARD_BITS;
    localparam int     SAT_BITS  = (COORD_W < 32) ? COORD_W : 32;

    rotated_t expected_rotations[$];
    longint   atan_q16[32];
    int       error_count;
    int       checked_count;
    int       saturated_count;

    function new();
      atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      error_count = 0;
      checked_count = 0;
      saturated_count = 0;
    endfunction

    task report(input string msg);
      if (error_count < 100) $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    // Offset times the CORDIC gain, rounded half away from zero, with guard bits kept.
    function longint gain_scale(input longint d);
      longint unsigned mag, prod, q;
      mag  = (d < 0) ? longint'(-d) : d;
      prod = mag * 64'(rpp_pkg::GAIN_Q30);
      q    = (prod + (64'd1 << (29 - GB))) >> (30 - GB);
      return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Drops the guard bits (round half up), adds the pivot back and clips.
    function longint settle(input longint v, input longint pivot, inout bit ovf);
      longint hi, lo, r;
      hi = (64'sd1 <<< (SAT_BITS - 1)) - 1;
      lo = -hi - 1;
      r  = ((v + (64'sd1 <<< (GB - 1))) >>> GB) + pivot;
      if (r > hi) begin
        ovf = 1'b1;
        return hi;
      end
      if (r < lo) begin
        ovf = 1'b1;
        return lo;
      end
      return r;
    endfunction

    function rotated_t rotate_about_pivot(input point_item_t it);
      longint px, py, x, y, z, t, xs, ys;
      bit ovf;
      rotated_t res;
      px  = it.pivot_x;
      py  = it.pivot_y;
      x   = gain_scale(longint'(it.point_x) - px);
      y   = gain_scale(longint'(it.point_y) - py);
      ovf = 1'b0;
      // Exact reduction to [-180, 180), then a quarter-turn swap into [-90, 90].
      z = longint'(it.angle_deg) % FULL_T;
      if (z < 0) z += FULL_T;
      if (z >= HALF_T) z -= FULL_T;
      if (z > QUARTER_T) begin
        t = x; x = -y; y = t;
        z -= QUARTER_T;
      end else if (z < -QUARTER_T) begin
        t = x; x = y; y = -t;
        z += QUARTER_T;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_q16[i];
        end else begin
          x += ys; y -= xs; z += atan_q16[i];
        end
      end
      res.x   = 32'(settle(x, px, ovf));
      res.y   = 32'(settle(y, py, ovf));
      res.ovf = ovf;
      return res;
    endfunction

    function void note_point(input point_item_t it);
      rotated_t r;
      r = rotate_about_pivot(it);
      if (r.ovf) saturated_count++;
      expected_rotations.insert(expected_rotations.size(), r);
    endfunction

    task check_result(input rotated_t got);
      rotated_t want;
      if (expected_rotations.size() == 0) begin
        report($sformatf("result (%0d, %0d, ovf %0b) with no transaction pending",
                         got.x, got.y, got.ovf));
        return;
      end
      want = expected_rotations.pop_front();
      checked_count++;
      if (got.x !== want.x)
        report($sformatf("result %0d rotated_x: got %0d expected %0d",
                         checked_count, got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("result %0d rotated_y: got %0d expected %0d",
                         checked_count, got.y, want.y));
      if (got.ovf !== want.ovf)
        report($sformatf("result %0d overflow: got %0b expected %0b",
                         checked_count, got.ovf, want.ovf));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  logic signed [31:0] pivot_x = '0;
  logic signed [31:0] pivot_y = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] angle_deg = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] rotated_x;
  logic signed [31:0] rotated_y;
  logic overflow;

  rotation_scoreboard rotations;

  // 0: no idling, 1: light idling, 2: heavy idling. quiet turns idling off at the end.
  int  idle_mode = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  cycle_count = 0;
  int  directed_count = 0;

  rotate_point_about_pivot_unit #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STAGES(STAGES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .pivot_x     (pivot_x),
    .pivot_y     (pivot_y),
    .point_x     (point_x),
    .point_y     (point_y),
    .angle_deg   (angle_deg),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .rotated_x   (rotated_x),
    .rotated_y   (rotated_y),
    .overflow    (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Both channels are observed at the rising edge, before the unit's registers move.
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && !point_stall)
        rotations.note_point('{pivot_x, pivot_y, point_x, point_y, angle_deg});
      if (result_valid && !result_stall)
        rotations.check_result('{rotated_x, rotated_y, overflow});
    end
  end

  // Result side: random stall bursts, more often in heavy mode.
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 15 : 2) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic point_item_t mk(input int px, input int py, input int x, input int y,
                                     input int a);
    point_item_t it;
    it.pivot_x   = px;
    it.pivot_y   = py;
    it.point_x   = x;
    it.point_y   = y;
    it.angle_deg = a;
    return it;
  endfunction

  // Presents one transaction, after an optional gap, and holds it until accepted.
  task automatic send_point(input point_item_t it);
    int gap;
    gap = 0;
    if (!quiet && idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 7 : 1) == 0)
      gap = $urandom_range(1, 18);
    @(negedge clk);
    repeat (gap) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    point_valid <= 1'b1;
    pivot_x     <= it.pivot_x;
    pivot_y     <= it.pivot_y;
    point_x     <= it.point_x;
    point_y     <= it.point_y;
    angle_deg   <= it.angle_deg;
    do @(posedge clk); while (point_stall);
  endtask

  task automatic send_directed(input point_item_t it);
    send_point(it);
    directed_count++;
  endtask

  initial begin
    point_item_t it;
    int kind;
    int offset_x, offset_y;

    rotations = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: quadrant edges, angle extremes, saturation and rounding corners.
    send_directed(mk(0, 0, 0, 0, 0));
    send_directed(mk(0, 0, DEG, 0, 90 * DEG));
    send_directed(mk(DEG, 2 * DEG, 5 * DEG, -3 * DEG, 180 * DEG));
    send_directed(mk(DEG, 2 * DEG, 5 * DEG, -3 * DEG, -180 * DEG));
    send_directed(mk(0, 0, 7 * DEG, 3 * DEG, 270 * DEG));
    send_directed(mk(0, 0, 7 * DEG, 3 * DEG, -90 * DEG));
    send_directed(mk(0, 0, 7 * DEG, 3 * DEG, 90 * DEG + 1));
    send_directed(mk(0, 0, 7 * DEG, 3 * DEG, -90 * DEG - 1));
    send_directed(mk(-DEG, DEG, 9 * DEG, 4 * DEG, 360 * DEG));
    send_directed(mk(123456, -654321, 1000000, 2000000, 32'sh7FFF_FFFF));
    send_directed(mk(123456, -654321, 1000000, 2000000, 32'sh8000_0000));
    send_directed(mk(0, 0, 100 * DEG, -50 * DEG, -1));
    send_directed(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0));
    send_directed(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     180 * DEG));
    send_directed(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     180 * DEG));
    send_directed(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     45 * DEG));
    send_directed(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     -45 * DEG));
    send_directed(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF));
    send_directed(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000));
    send_directed(mk(-5 * DEG, 8 * DEG, -5 * DEG, 8 * DEG, 33 * DEG));
    send_directed(mk(0, 0, -1, -1, DEG));
    send_directed(mk(0, 0, 32'sh7FFF_FFFF, 0, 90 * DEG));
    send_directed(mk(2 * DEG, 0, 12 * DEG, 6 * DEG, 765 * DEG));
    send_directed(mk(0, -DEG, 4 * DEG, 4 * DEG, -359 * DEG));

    // Random part: realistic geometry in four draws of ten, plus raw bit patterns, angles
    // right at the quarter-turn boundaries and transactions built to saturate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idle_mode = $urandom_range(0, 2);
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      kind = $urandom_range(0, 9);
      unique case (kind)
        0, 1: begin
          it = {$urandom, $urandom, $urandom, $urandom, $urandom};
        end
        2, 3, 4, 5: begin
          it.pivot_x   = int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
          it.pivot_y   = int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
          offset_x     = int'($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
          offset_y     = int'($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000;
          it.point_x   = it.pivot_x + offset_x;
          it.point_y   = it.pivot_y + offset_y;
          it.angle_deg = int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
        end
        6, 7: begin
          it.pivot_x   = int'($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000;
          it.pivot_y   = int'($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000;
          it.point_x   = int'($urandom_range(0, 32'hFFF_FFFF)) - 32'sh800_0000;
          it.point_y   = int'($urandom_range(0, 32'hFFF_FFFF)) - 32'sh800_0000;
          it.angle_deg = (int'($urandom_range(0, 16)) - 8) * 90 * DEG
                         + int'($urandom_range(0, 8)) - 4;
        end
        8: begin
          it.pivot_x   = {($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 30'($urandom)};
          it.pivot_y   = {($urandom_range(0, 1) != 0) ? 2'b01 : 2'b10, 30'($urandom)};
          it.point_x   = ~it.pivot_x ^ 32'($urandom_range(0, 32'hFFFF));
          it.point_y   = ~it.pivot_y ^ 32'($urandom_range(0, 32'hFFFF));
          it.angle_deg = $urandom;
        end
        default: begin
          it.pivot_x   = int'($urandom_range(0, 64)) - 32;
          it.pivot_y   = int'($urandom_range(0, 64)) - 32;
          it.point_x   = it.pivot_x + int'($urandom_range(0, 6)) - 3;
          it.point_y   = it.pivot_y + int'($urandom_range(0, 6)) - 3;
          it.angle_deg = int'($urandom_range(0, 720)) * (DEG / 2) - 180 * DEG;
        end
      endcase
      send_point(it);
    end

    @(negedge clk);
    point_valid <= 1'b0;

    // Drain, then keep watching for a while so that stray results are caught.
    while (rotations.expected_rotations.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (rotations.expected_rotations.size() != 0)
      rotations.report($sformatf("%0d results never arrived",
                                 rotations.expected_rotations.size()));

    $display("Checked %0d rotations (%0d directed, the rest random), %0d of them saturating.",
             rotations.checked_count, directed_count, rotations.saturated_count);
    $display("Stimulus spanned every quadrant and angle extreme, with bursts of idling on "
             , "both channels.");
    if (rotations.error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", rotations.error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/rpp_pkg.sv
sv/rpp_prep.sv
sv/rpp_cordic_stage.sv
sv/rpp_finish.sv
sv/rotate_point_about_pivot_unit.sv
test/testbench.sv
